### rtl/thermal_fan_hysteresis_monitor_defines.svh
// Assertion macros shared by the thermal fan hysteresis monitor checker.
`ifndef THERMAL_FAN_HYSTERESIS_MONITOR_DEFINES_SVH
`define THERMAL_FAN_HYSTERESIS_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFHM_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TFHM_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tfhm_pkg.sv
// Shared constants and types of the thermal fan hysteresis monitor.
`default_nettype none

package tfhm_pkg;

    // Defaults of the top-level parameters
    localparam int DEF_AVERAGE_LENGTH = 10;
    localparam int DEF_SENSOR_COUNT   = 3;
    localparam int DEF_ADC_BITS       = 12;

    // Field widths
    localparam int SENSOR_W = 2;
    localparam int TEMP_W   = 16;
    localparam int WHOLE_W  = 8;
    localparam int THRESH_W = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int OFFSET_REGS = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_START_THRESHOLD = 3'd0,
        REG_STOP_THRESHOLD  = 3'd1,
        REG_SILO_SENSOR     = 3'd2,
        REG_OUTSIDE_SENSOR  = 3'd3,
        REG_SENSOR_OFFSET_0 = 3'd4,
        REG_SENSOR_OFFSET_1 = 3'd5,
        REG_SENSOR_OFFSET_2 = 3'd6
    } tfhm_reg_t;

    localparam logic signed [THRESH_W-1:0] RST_START_THRESHOLD = 8'sd5;
    localparam logic signed [THRESH_W-1:0] RST_STOP_THRESHOLD  = 8'sd2;
    localparam logic [SENSOR_W-1:0]        RST_SILO_SENSOR     = 2'd1;
    localparam logic [SENSOR_W-1:0]        RST_OUTSIDE_SENSOR  = 2'd0;

    // ADC difference to millivolt-like scale: d * 2^VOLT_SHIFT / full scale
    localparam int VOLT_SHIFT = 10;
    localparam int VOLT_W     = 11;
    localparam logic [VOLT_W-1:0] VOLT_OFFSET = 11'd115;
    localparam int VOLT_MAG_W = 10;

    // Volt to 8.8 degrees: (v - offset) * 2^TEMP_SHIFT / TEMP_DIV, by reciprocal
    localparam int TEMP_DIV   = 9;
    localparam int TEMP_SHIFT = 8;
    localparam int TEMP_N     = VOLT_MAG_W + TEMP_SHIFT;
    localparam int TEMP_L     = 4;
    localparam logic [63:0] TEMP_RECIP =
        ((64'd1 << (TEMP_N + TEMP_L)) + 64'(TEMP_DIV) - 64'd1) / 64'(TEMP_DIV);
    localparam int TEMP_RECIP_W     = TEMP_N + 1;
    localparam int TEMP_RECIP_SHIFT = TEMP_N + TEMP_L - TEMP_SHIFT;
    localparam int TEMP_Q_W         = 15;

endpackage

`default_nettype wire

### rtl/thermal_fan_hysteresis_monitor.sv
// Top level of the thermal fan hysteresis monitor pipeline.
// Each input beat is one sampling tick for the next sensor in round-robin order
// (0, 1, ..., SENSOR_COUNT-1). The block accepts one beat per clock while the
// output is not stalled and returns one result beat for each through the seven
// stages (input register, scale, divide by nine, offset, running-sum update,
// divide by the average length, fan decision into the output register); the
// per-sensor running sum is updated by one add and one subtract. A stalled output
// lets the pipeline keep filling until every stage holds a beat. The user must
// write configuration through cfg_wr_en/cfg_index/cfg_data only while the
// pipeline is empty, which the block does not enforce; writes to indexes beyond the last register are dropped.
`default_nettype none

module thermal_fan_hysteresis_monitor #(
    parameter int AVERAGE_LENGTH = tfhm_pkg::DEF_AVERAGE_LENGTH,
    parameter int SENSOR_COUNT   = tfhm_pkg::DEF_SENSOR_COUNT,
    parameter int ADC_BITS       = tfhm_pkg::DEF_ADC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ADC_BITS-1:0]                  adc_positive,
    input  logic [ADC_BITS-1:0]                  adc_negative,
    input  logic                                 cfg_wr_en,
    input  logic [tfhm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tfhm_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tfhm_pkg::SENSOR_W-1:0]        sensor_served,
    output logic signed [tfhm_pkg::TEMP_W-1:0]   raw_temperature,
    output logic signed [tfhm_pkg::WHOLE_W-1:0]  filtered_temperature,
    output logic                                 fan_on
);

    localparam int STAGES  = 7;
    localparam int SIDX_W  = $clog2(SENSOR_COUNT);
    localparam int TEMP_W  = tfhm_pkg::TEMP_W;
    localparam int WHOLE_W = tfhm_pkg::WHOLE_W;
    localparam int THR_W   = tfhm_pkg::THRESH_W;
    localparam int SEL_W   = tfhm_pkg::SENSOR_W;
    localparam int VOLT_W  = tfhm_pkg::VOLT_W;
    localparam int VMAG_W  = tfhm_pkg::VOLT_MAG_W;
    localparam int Q_W     = tfhm_pkg::TEMP_Q_W;
    localparam int TQ_W    = TEMP_W + 1;
    localparam int TSUM_W  = TEMP_W + 2;
    localparam int DIFF_W  = WHOLE_W + 1;

    // Full-scale reciprocal: volt = (d * RECIP_FS) >> (2 * ADC_BITS)
    localparam logic [63:0] FS = (64'd1 << ADC_BITS) - 64'd1;
    localparam logic [63:0] RECIP_FS_FULL =
        ((64'd1 << (2 * ADC_BITS + tfhm_pkg::VOLT_SHIFT)) + FS - 64'd1) / FS;
    localparam int RECIP_FS_W = ADC_BITS + tfhm_pkg::VOLT_SHIFT + 1;
    localparam int PROD1_W    = ADC_BITS + RECIP_FS_W;

    localparam int PROD2_W = VMAG_W + tfhm_pkg::TEMP_RECIP_W;

    // Average-length reciprocal: avg = (|sum| * RECIP_LEN) >> (SUM_W + AVG_L)
    localparam int AVG_L = $clog2(AVERAGE_LENGTH);
    localparam int SUM_W = TEMP_W + AVG_L;
    localparam logic [63:0] LEN_D = 64'(AVERAGE_LENGTH);
    localparam logic [63:0] RECIP_LEN_FULL =
        ((64'd1 << (SUM_W + AVG_L)) + LEN_D - 64'd1) / LEN_D;
    localparam int RECIP_LEN_W = SUM_W + 1;
    localparam int PROD3_W     = SUM_W + RECIP_LEN_W;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

    // Configuration registers
    logic signed [THR_W-1:0]  start_reg;
    logic signed [THR_W-1:0]  stop_reg;
    logic [SEL_W-1:0]         silo_reg;
    logic [SEL_W-1:0]         outside_reg;
    logic signed [TEMP_W-1:0] offset_reg [tfhm_pkg::OFFSET_REGS];

    // Pipeline control
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] ready;
    logic [STAGES-1:0] load;

    logic [SIDX_W-1:0] sensor_cnt_reg;
    logic [SIDX_W-1:0] sensor_cnt_next;

    // Stage registers
    logic [ADC_BITS-1:0]       s0_pos_reg;
    logic [ADC_BITS-1:0]       s0_neg_reg;
    logic [SIDX_W-1:0]         s0_sensor_reg;
    logic [VOLT_W-1:0]         s1_volt_reg;
    logic [SIDX_W-1:0]         s1_sensor_reg;
    logic [Q_W-1:0]            s2_q_reg;
    logic                      s2_below_reg;
    logic [SIDX_W-1:0]         s2_sensor_reg;
    logic signed [TEMP_W-1:0]  s3_raw_reg;
    logic [SIDX_W-1:0]         s3_sensor_reg;
    logic signed [SUM_W-1:0]   s4_sum_reg;
    logic signed [TEMP_W-1:0]  s4_raw_reg;
    logic [SIDX_W-1:0]         s4_sensor_reg;
    logic [TEMP_W-1:0]         s5_avg_mag_reg;
    logic                      s5_avg_neg_reg;
    logic signed [TEMP_W-1:0]  s5_raw_reg;
    logic [SIDX_W-1:0]         s5_sensor_reg;

    logic [SEL_W-1:0]          sensor_served_reg;
    logic signed [TEMP_W-1:0]  raw_temperature_reg;
    logic signed [WHOLE_W-1:0] filtered_reg;
    logic                      fan_reg;
    logic                      fan_next;
    logic signed [WHOLE_W-1:0] temp_reg  [SENSOR_COUNT];
    logic signed [WHOLE_W-1:0] temp_next [SENSOR_COUNT];

    // Combinational stage results
    logic [ADC_BITS-1:0]        adc_diff;
    logic [PROD1_W-1:0]         prod1;
    logic                       volt_below;
    logic [VMAG_W-1:0]          volt_mag;
    logic [PROD2_W-1:0]         prod2;
    logic signed [TQ_W-1:0]     temp_q;
    logic signed [TEMP_W-1:0]   offset_sel;
    logic signed [TSUM_W-1:0]   temp_sum;
    logic signed [TEMP_W-1:0]   raw_sat;
    logic signed [SUM_W-1:0]    sum_new;
    logic                       sum_neg;
    logic [SUM_W-1:0]           sum_mag;
    logic [PROD3_W-1:0]         prod3;
    logic signed [TEMP_W:0]     avg_val;
    logic signed [WHOLE_W-1:0]  whole;
    logic signed [WHOLE_W-1:0]  silo_temp;
    logic signed [WHOLE_W-1:0]  outside_temp;
    logic signed [DIFF_W-1:0]   temp_diff;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= tfhm_pkg::RST_START_THRESHOLD;
            stop_reg    <= tfhm_pkg::RST_STOP_THRESHOLD;
            silo_reg    <= tfhm_pkg::RST_SILO_SENSOR;
            outside_reg <= tfhm_pkg::RST_OUTSIDE_SENSOR;
            for (int k = 0; k < tfhm_pkg::OFFSET_REGS; k++)
            begin
                offset_reg[k] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tfhm_pkg::REG_START_THRESHOLD: start_reg      <= cfg_data[THR_W-1:0];
                tfhm_pkg::REG_STOP_THRESHOLD:  stop_reg       <= cfg_data[THR_W-1:0];
                tfhm_pkg::REG_SILO_SENSOR:     silo_reg       <= cfg_data[SEL_W-1:0];
                tfhm_pkg::REG_OUTSIDE_SENSOR:  outside_reg    <= cfg_data[SEL_W-1:0];
                tfhm_pkg::REG_SENSOR_OFFSET_0: offset_reg[0]  <= cfg_data[TEMP_W-1:0];
                tfhm_pkg::REG_SENSOR_OFFSET_1: offset_reg[1]  <= cfg_data[TEMP_W-1:0];
                tfhm_pkg::REG_SENSOR_OFFSET_2: offset_reg[2]  <= cfg_data[TEMP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance a stage when it is empty or the stage after it moves
    always_comb
    begin
        ready[STAGES-1] = !vld_reg[STAGES-1] || !out_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            ready[i] = !vld_reg[i] || ready[i+1];
        end
        load[0] = in_valid && ready[0];
        for (int i = 1; i < STAGES; i++)
        begin
            load[i] = vld_reg[i-1] && ready[i];
        end
    end

    assign vld_next  = {vld_reg[STAGES-2:0], in_valid};
    assign in_stall  = !ready[0];
    assign out_valid = vld_reg[STAGES-1];

    assign sensor_cnt_next = (sensor_cnt_reg == SIDX_W'(SENSOR_COUNT - 1))
                             ? '0 : sensor_cnt_reg + 1'b1;

    // Hold valid bits and the round-robin sensor count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            sensor_cnt_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (ready[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
            if (load[0])
            begin
                sensor_cnt_reg <= sensor_cnt_next;
            end
        end
    end

    // Stage 1: clamp the channel difference and scale by the full-scale reciprocal
    assign adc_diff = (s0_pos_reg > s0_neg_reg) ? (s0_pos_reg - s0_neg_reg) : '0;
    assign prod1    = PROD1_W'(adc_diff) * PROD1_W'(RECIP_FS_FULL[RECIP_FS_W-1:0]);

    // Stage 2: remove the sensor offset voltage and divide by nine
    assign volt_below = s1_volt_reg < tfhm_pkg::VOLT_OFFSET;
    assign volt_mag   = volt_below ? VMAG_W'(tfhm_pkg::VOLT_OFFSET - s1_volt_reg)
                                   : VMAG_W'(s1_volt_reg - tfhm_pkg::VOLT_OFFSET);
    assign prod2 = PROD2_W'(volt_mag)
                   * PROD2_W'(tfhm_pkg::TEMP_RECIP[tfhm_pkg::TEMP_RECIP_W-1:0]);

    // Stage 3: restore sign, add the calibration offset, saturate
    assign temp_q = s2_below_reg ? -TQ_W'(s2_q_reg) : TQ_W'(s2_q_reg);

    always_comb
    begin
        offset_sel = '0;
        for (int k = 0; k < tfhm_pkg::OFFSET_REGS; k++)
        begin
            if (int'(s2_sensor_reg) == k)
            begin
                offset_sel = offset_reg[k];
            end
        end
    end

    assign temp_sum = TSUM_W'(temp_q) + TSUM_W'(offset_sel);

    always_comb
    begin
        if ((&temp_sum[TSUM_W-1:TEMP_W-1]) || !(|temp_sum[TSUM_W-1:TEMP_W-1]))
        begin
            raw_sat = temp_sum[TEMP_W-1:0];
        end
        else if (temp_sum[TSUM_W-1])
        begin
            raw_sat = TEMP_MIN;
        end
        else
        begin
            raw_sat = TEMP_MAX;
        end
    end

    // Stage 4: update the sensor's history and running sum
    tfhm_history #(
        .AVERAGE_LENGTH (AVERAGE_LENGTH),
        .SENSOR_COUNT   (SENSOR_COUNT)
    ) u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .upd     (load[4]),
        .sensor  (s3_sensor_reg),
        .raw     (s3_raw_reg),
        .sum_new (sum_new)
    );

    // Stage 5: divide the sum magnitude by the average length
    assign sum_neg = s4_sum_reg[SUM_W-1];
    assign sum_mag = sum_neg ? SUM_W'(-s4_sum_reg) : SUM_W'(s4_sum_reg);
    assign prod3   = PROD3_W'(sum_mag) * PROD3_W'(RECIP_LEN_FULL[RECIP_LEN_W-1:0]);

    // Stage 6: whole degrees, per-sensor temperature and fan hysteresis
    assign avg_val = s5_avg_neg_reg ? -{1'b0, s5_avg_mag_reg} : {1'b0, s5_avg_mag_reg};
    assign whole   = avg_val[TEMP_W-1 -: WHOLE_W];

    always_comb
    begin
        silo_temp    = '0;
        outside_temp = '0;
        for (int r = 0; r < SENSOR_COUNT; r++)
        begin
            temp_next[r] = (int'(s5_sensor_reg) == r) ? whole : temp_reg[r];
        end
        for (int r = 0; r < SENSOR_COUNT; r++)
        begin
            if (int'(silo_reg) == r)
            begin
                silo_temp = temp_next[r];
            end
            if (int'(outside_reg) == r)
            begin
                outside_temp = temp_next[r];
            end
        end
    end

    assign temp_diff = DIFF_W'(silo_temp) - DIFF_W'(outside_temp);

    always_comb
    begin
        if (temp_diff >= DIFF_W'(start_reg))
        begin
            fan_next = 1'b1;
        end
        else if (temp_diff <= DIFF_W'(stop_reg))
        begin
            fan_next = 1'b0;
        end
        else
        begin
            fan_next = fan_reg;
        end
    end

    // Hold per-sensor temperatures and the fan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_reg <= 1'b0;
            for (int r = 0; r < SENSOR_COUNT; r++)
            begin
                temp_reg[r] <= '0;
            end
        end
        else if (load[6])
        begin
            fan_reg <= fan_next;
            for (int r = 0; r < SENSOR_COUNT; r++)
            begin
                temp_reg[r] <= temp_next[r];
            end
        end
    end

    // Move payload through the stages
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s0_pos_reg    <= adc_positive;
            s0_neg_reg    <= adc_negative;
            s0_sensor_reg <= sensor_cnt_reg;
        end
        if (load[1])
        begin
            s1_volt_reg   <= prod1[2*ADC_BITS +: VOLT_W];
            s1_sensor_reg <= s0_sensor_reg;
        end
        if (load[2])
        begin
            s2_q_reg      <= prod2[tfhm_pkg::TEMP_RECIP_SHIFT +: Q_W];
            s2_below_reg  <= volt_below;
            s2_sensor_reg <= s1_sensor_reg;
        end
        if (load[3])
        begin
            s3_raw_reg    <= raw_sat;
            s3_sensor_reg <= s2_sensor_reg;
        end
        if (load[4])
        begin
            s4_sum_reg    <= sum_new;
            s4_raw_reg    <= s3_raw_reg;
            s4_sensor_reg <= s3_sensor_reg;
        end
        if (load[5])
        begin
            s5_avg_mag_reg <= prod3[SUM_W+AVG_L +: TEMP_W];
            s5_avg_neg_reg <= sum_neg;
            s5_raw_reg     <= s4_raw_reg;
            s5_sensor_reg  <= s4_sensor_reg;
        end
        if (load[6])
        begin
            sensor_served_reg   <= SEL_W'(s5_sensor_reg);
            raw_temperature_reg <= s5_raw_reg;
            filtered_reg        <= whole;
        end
    end

    assign sensor_served        = sensor_served_reg;
    assign raw_temperature      = raw_temperature_reg;
    assign filtered_temperature = filtered_reg;
    assign fan_on               = fan_reg;

endmodule

`default_nettype wire

### rtl/tfhm_history.sv
// Per-sensor sample history with running sums for the moving average.
`default_nettype none

module tfhm_history #(
    parameter int AVERAGE_LENGTH = tfhm_pkg::DEF_AVERAGE_LENGTH,
    parameter int SENSOR_COUNT   = tfhm_pkg::DEF_SENSOR_COUNT,
    localparam int SIDX_W = $clog2(SENSOR_COUNT),
    localparam int SUM_W  = tfhm_pkg::TEMP_W + $clog2(AVERAGE_LENGTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              upd,
    input  logic [SIDX_W-1:0]                 sensor,
    input  logic signed [tfhm_pkg::TEMP_W-1:0] raw,
    output logic signed [SUM_W-1:0]           sum_new
);

    localparam logic signed [SUM_W-1:0] LEN_S = SUM_W'(AVERAGE_LENGTH);

    logic signed [tfhm_pkg::TEMP_W-1:0] hist_reg [SENSOR_COUNT][AVERAGE_LENGTH];
    logic signed [SUM_W-1:0]            sum_reg  [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0]            primed_reg;

    logic signed [tfhm_pkg::TEMP_W-1:0] oldest;
    logic signed [SUM_W-1:0]            sum_cur;
    logic                               primed_cur;

    // Select the row of the sensor being served
    always_comb
    begin
        oldest     = '0;
        sum_cur    = '0;
        primed_cur = 1'b0;
        for (int r = 0; r < SENSOR_COUNT; r++)
        begin
            if (int'(sensor) == r)
            begin
                oldest     = hist_reg[r][0];
                sum_cur    = sum_reg[r];
                primed_cur = primed_reg[r];
            end
        end
    end

    // Drop the oldest sample and add the new one, or prime with the first sample
    assign sum_new = primed_cur ? (sum_cur - SUM_W'(oldest) + SUM_W'(raw))
                                : (SUM_W'(raw) * LEN_S);

    // Track which rows hold real samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= '0;
        end
        else if (upd)
        begin
            for (int r = 0; r < SENSOR_COUNT; r++)
            begin
                if (int'(sensor) == r)
                begin
                    primed_reg[r] <= 1'b1;
                end
            end
        end
    end

    // Advance the served row and store its new sum
    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            for (int r = 0; r < SENSOR_COUNT; r++)
            begin
                if (int'(sensor) == r)
                begin
                    if (!primed_reg[r])
                    begin
                        for (int i = 0; i < AVERAGE_LENGTH; i++)
                        begin
                            hist_reg[r][i] <= raw;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < AVERAGE_LENGTH - 1; i++)
                        begin
                            hist_reg[r][i] <= hist_reg[r][i+1];
                        end
                        hist_reg[r][AVERAGE_LENGTH-1] <= raw;
                    end
                    sum_reg[r] <= sum_new;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/tfhm_checker.sv
// Port-level checker for the thermal fan hysteresis monitor, bound to the top level.
`default_nettype none

`include "thermal_fan_hysteresis_monitor_defines.svh"

module tfhm_checker #(
    parameter int SENSOR_COUNT = tfhm_pkg::DEF_SENSOR_COUNT
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [tfhm_pkg::SENSOR_W-1:0]        sensor_served,
    input logic signed [tfhm_pkg::TEMP_W-1:0]   raw_temperature,
    input logic signed [tfhm_pkg::WHOLE_W-1:0]  filtered_temperature,
    input logic                                 fan_on
);

    localparam int SEL_W = tfhm_pkg::SENSOR_W;

    logic [SEL_W-1:0] exp_sensor_reg;
    logic [SEL_W-1:0] exp_sensor_next;

    // Expect result beats to walk the sensors in round-robin order
    assign exp_sensor_next = (exp_sensor_reg == SEL_W'(SENSOR_COUNT - 1))
                             ? '0 : exp_sensor_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_sensor_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            exp_sensor_reg <= exp_sensor_next;
        end
    end

    `TFHM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({sensor_served, raw_temperature, filtered_temperature, fan_on}), "result beat changed while stalled")
    `TFHM_ASSERT_IMPLY(a_round_robin, clk, rst_n, out_valid, sensor_served == exp_sensor_reg, "result beat out of round-robin order")
    `TFHM_ASSERT_IMPLY(a_sensor_range, clk, rst_n, out_valid, int'(sensor_served) < SENSOR_COUNT, "served sensor index out of range")
    `TFHM_ASSERT_IMPLY(a_accept_when_drained, clk, rst_n, !out_valid, !in_stall, "input stalled with an empty output stage")

endmodule

bind thermal_fan_hysteresis_monitor tfhm_checker #(
    .SENSOR_COUNT (SENSOR_COUNT)
) u_tfhm_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_stall             (in_stall),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .sensor_served        (sensor_served),
    .raw_temperature      (raw_temperature),
    .filtered_temperature (filtered_temperature),
    .fan_on               (fan_on)
);

`default_nettype wire

### tb/thermal_fan_hysteresis_monitor_test.sv
// Self-checking testbench for the thermal fan hysteresis monitor.
`default_nettype none

module thermal_fan_hysteresis_monitor_test;

    import tfhm_pkg::*;

    localparam int AVG_LEN     = DEF_AVERAGE_LENGTH;
    localparam int SENSORS     = DEF_SENSOR_COUNT;
    localparam int ADC_W       = DEF_ADC_BITS;
    localparam int FULL_SCALE  = (1 << ADC_W) - 1;
    localparam int ZERO_POINT  = 115;
    localparam int DEG_DIV     = 9;
    localparam int LONG_HOLD   = 40;
    localparam int DRAIN_LIMIT = 400;
    localparam int RUN_LIMIT   = 1000000;

    // Index past the last register; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_BEYOND_LAST = 3'd7;

    typedef struct packed {
        logic [SENSOR_W-1:0]        sensor;
        logic signed [TEMP_W-1:0]   raw;
        logic signed [WHOLE_W-1:0]  whole;
        logic                       fan;
    } sample_result_t;

    // Predicted monitor state plus the queue of readings still owed by the block
    class fan_monitor_model;
        int start_level;
        int stop_level;
        int silo_idx;
        int outside_idx;
        int offset_q88[SENSORS];
        int history[SENSORS*AVG_LEN];
        bit primed[SENSORS];
        int next_sensor;
        int whole_deg[SENSORS];
        bit fan_running;
        sample_result_t expected_readings[$];
        int error_count;
        int printed;

        function void clear();
            start_level = RST_START_THRESHOLD;
            stop_level  = RST_STOP_THRESHOLD;
            silo_idx    = RST_SILO_SENSOR;
            outside_idx = RST_OUTSIDE_SENSOR;
            for (int i = 0; i < SENSORS; i++)
            begin
                offset_q88[i] = 0;
                primed[i]     = 1'b0;
                whole_deg[i]  = 0;
            end
            for (int i = 0; i < SENSORS*AVG_LEN; i++)
                history[i] = 0;
            next_sensor = 0;
            fan_running = 1'b0;
            expected_readings.delete();
            error_count = 0;
            printed     = 0;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        task report(input string msg);
            error_count++;
            if (printed < 200)
            begin
                printed++;
                $display("ERROR @%0t: %s", $time, msg);
            end
        endtask

        function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_START_THRESHOLD: start_level   = $signed(value[THRESH_W-1:0]);
                REG_STOP_THRESHOLD:  stop_level    = $signed(value[THRESH_W-1:0]);
                REG_SILO_SENSOR:     silo_idx      = value[SENSOR_W-1:0];
                REG_OUTSIDE_SENSOR:  outside_idx   = value[SENSOR_W-1:0];
                REG_SENSOR_OFFSET_0: offset_q88[0] = $signed(value);
                REG_SENSOR_OFFSET_1: offset_q88[1] = $signed(value);
                REG_SENSOR_OFFSET_2: offset_q88[2] = $signed(value);
                default: ;
            endcase
        endfunction

        // A selector naming no sensor reads as zero degrees
        function int temp_at(input int idx);
            return (idx < SENSORS) ? whole_deg[idx] : 0;
        endfunction

        // Convert one beat, update the averaging history and the fan decision
        function void note_sample(input logic [ADC_W-1:0] pos, input logic [ADC_W-1:0] neg);
            int s;
            int d;
            int volt;
            int t;
            int sum;
            int avg;
            int diff;
            sample_result_t r;
            s = next_sensor;
            d = (pos > neg) ? int'(pos) - int'(neg) : 0;
            volt = (d * 1024) / FULL_SCALE;
            t = ((volt - ZERO_POINT) * 256) / DEG_DIV + offset_q88[s];
            if (t > 32767)
                t = 32767;
            else if (t < -32768)
                t = -32768;
            // Prime the whole history on the first beat of a sensor
            if (!primed[s])
            begin
                for (int i = 0; i < AVG_LEN; i++)
                    history[s*AVG_LEN + i] = t;
                primed[s] = 1'b1;
            end
            else
            begin
                for (int i = 0; i < AVG_LEN - 1; i++)
                    history[s*AVG_LEN + i] = history[s*AVG_LEN + i + 1];
                history[s*AVG_LEN + AVG_LEN - 1] = t;
            end
            sum = 0;
            for (int i = 0; i < AVG_LEN; i++)
                sum += history[s*AVG_LEN + i];
            avg = sum / AVG_LEN;
            whole_deg[s] = avg >>> 8;
            next_sensor = (s + 1) % SENSORS;
            // Start wins when both thresholds are met
            diff = temp_at(silo_idx) - temp_at(outside_idx);
            if (diff >= start_level)
                fan_running = 1'b1;
            else if (diff <= stop_level)
                fan_running = 1'b0;
            r.sensor = SENSOR_W'(s);
            r.raw    = TEMP_W'(t);
            r.whole  = WHOLE_W'(whole_deg[s]);
            r.fan    = fan_running;
            expected_readings.push_back(r);
        endfunction

        task check_result(input logic [SENSOR_W-1:0] sensor,
                          input logic signed [TEMP_W-1:0] raw,
                          input logic signed [WHOLE_W-1:0] whole,
                          input logic fan);
            sample_result_t want;
            if (expected_readings.size() == 0)
            begin
                report($sformatf("unexpected beat: sensor %0d raw %0d filtered %0d fan %0b",
                                 sensor, raw, whole, fan));
                return;
            end
            want = expected_readings.pop_front();
            if (sensor !== want.sensor || raw !== want.raw ||
                whole !== want.whole || fan !== want.fan)
                report($sformatf(
                    "got/exp sensor %0d/%0d raw %0d/%0d filtered %0d/%0d fan %0b/%0b",
                    sensor, want.sensor, raw, want.raw, whole, want.whole, fan, want.fan));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [ADC_W-1:0] adc_positive;
    logic [ADC_W-1:0] adc_negative;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic out_valid;
    logic out_stall;
    logic [SENSOR_W-1:0] sensor_served;
    logic signed [TEMP_W-1:0] raw_temperature;
    logic signed [WHOLE_W-1:0] filtered_temperature;
    logic fan_on;

    fan_monitor_model fan_model;
    int gap_pct;
    int stall_pct;
    bit hold_request;

    thermal_fan_hysteresis_monitor i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .adc_positive         (adc_positive),
        .adc_negative         (adc_negative),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .sensor_served        (sensor_served),
        .raw_temperature      (raw_temperature),
        .filtered_temperature (filtered_temperature),
        .fan_on               (fan_on)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            fan_model.check_result(sensor_served, raw_temperature, filtered_temperature, fan_on);
    end

    // Drive output stall: random bursts, plus one long hold on request
    initial
    begin : receiver
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("thermal_fan_hysteresis_monitor test failed");
        $finish;
    end

    // Offer one beat and hold it until accepted, then maybe idle a burst
    task automatic send_sample(input logic [ADC_W-1:0] pos, input logic [ADC_W-1:0] neg);
        int burst;
        @(negedge clk);
        in_valid     <= 1'b1;
        adc_positive <= pos;
        adc_negative <= neg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fan_model.note_sample(pos, neg);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            burst = $urandom_range(1, 15);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (burst - 1) @(negedge clk);
        end
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Hold off until every expected beat has come back
    task automatic wait_drained();
        while (fan_model.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        fan_model.write_reg(idx, value);
    endtask

    task automatic cfg_done();
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Load a random register set; the wide form uses full-range data everywhere
    task automatic random_setup(input bit wide);
        int start_lvl;
        int stop_lvl;
        if (wide)
        begin
            cfg_write(REG_START_THRESHOLD, CFG_DATA_W'($urandom));
            cfg_write(REG_STOP_THRESHOLD, CFG_DATA_W'($urandom));
            cfg_write(REG_SILO_SENSOR, CFG_DATA_W'($urandom));
            cfg_write(REG_OUTSIDE_SENSOR, CFG_DATA_W'($urandom));
            cfg_write(REG_SENSOR_OFFSET_0, CFG_DATA_W'($urandom));
            cfg_write(REG_SENSOR_OFFSET_1, CFG_DATA_W'($urandom));
            cfg_write(REG_SENSOR_OFFSET_2, CFG_DATA_W'($urandom));
            cfg_write(REG_BEYOND_LAST, CFG_DATA_W'($urandom));
        end
        else
        begin
            stop_lvl  = $urandom_range(0, 16) - 8;
            start_lvl = stop_lvl + $urandom_range(0, 12) - 2;
            cfg_write(REG_START_THRESHOLD, CFG_DATA_W'(start_lvl));
            cfg_write(REG_STOP_THRESHOLD, CFG_DATA_W'(stop_lvl));
            cfg_write(REG_SILO_SENSOR, CFG_DATA_W'($urandom_range(0, 2)));
            cfg_write(REG_OUTSIDE_SENSOR, CFG_DATA_W'($urandom_range(0, 3)));
            cfg_write(REG_SENSOR_OFFSET_0, CFG_DATA_W'($urandom_range(0, 4095) - 2048));
            cfg_write(REG_SENSOR_OFFSET_1, CFG_DATA_W'($urandom_range(0, 4095) - 2048));
            cfg_write(REG_SENSOR_OFFSET_2, CFG_DATA_W'($urandom_range(0, 4095) - 2048));
        end
        cfg_done();
    endtask

    // Mostly warm readings near a level, with raw noise and reversed pairs mixed in
    task automatic send_mixed(input int count, input int warm_level);
        logic [ADC_W-1:0] pos;
        logic [ADC_W-1:0] neg;
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                pos = ADC_W'($urandom);
                neg = ADC_W'($urandom);
            end
            else if (pick < 8)
            begin
                neg = ADC_W'($urandom_range(0, 63));
                pos = ADC_W'(warm_level + $urandom_range(0, 200));
            end
            else
            begin
                pos = ADC_W'($urandom_range(0, 2047));
                neg = ADC_W'(pos + $urandom_range(0, 2048));
            end
            send_sample(pos, neg);
        end
    endtask

    initial
    begin : main
        int phase;
        int wait_cycles;
        fan_model = new;
        fan_model.clear();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        adc_positive = '0;
        adc_negative = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_request = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: priming, clamping of a reversed pair to zero, the zero point
        send_sample(12'd0, 12'd4095);
        send_sample(12'd4095, 12'd0);
        send_sample(12'd0, 12'd0);
        send_sample(12'd459, 12'd0);
        send_sample(12'd460, 12'd0);
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd2048, 12'd2047);
        send_sample(12'd4095, 12'd1);
        send_sample(12'd1, 12'd4095);
        send_sample(12'd3000, 12'd1000);
        send_sample(12'd800, 12'd700);
        send_sample(12'd4095, 12'd0);
        drop_valid();
        wait_drained();

        // Threshold extremes, missing silo sensor, offsets that clamp both ways
        cfg_write(REG_START_THRESHOLD, 16'h0080);
        cfg_write(REG_STOP_THRESHOLD, 16'h007F);
        cfg_write(REG_SILO_SENSOR, 16'd3);
        cfg_write(REG_OUTSIDE_SENSOR, 16'd2);
        cfg_write(REG_SENSOR_OFFSET_0, 16'h7FFF);
        cfg_write(REG_SENSOR_OFFSET_1, 16'h8000);
        cfg_write(REG_SENSOR_OFFSET_2, 16'h0100);
        cfg_write(REG_BEYOND_LAST, 16'hFFFF);
        cfg_done();
        send_sample(12'd4095, 12'd0);
        send_sample(12'd0, 12'd4095);
        send_sample(12'd4095, 12'd0);
        send_sample(12'd0, 12'd0);
        send_sample(12'd4095, 12'd0);
        send_sample(12'd0, 12'd4095);
        drop_valid();
        wait_drained();

        // Overlapping thresholds: start at or below stop, fan must turn on
        cfg_write(REG_START_THRESHOLD, 16'hFFFB);
        cfg_write(REG_STOP_THRESHOLD, 16'd10);
        cfg_write(REG_SILO_SENSOR, 16'd0);
        cfg_write(REG_OUTSIDE_SENSOR, 16'd1);
        cfg_write(REG_SENSOR_OFFSET_0, 16'd0);
        cfg_write(REG_SENSOR_OFFSET_1, 16'd0);
        cfg_write(REG_SENSOR_OFFSET_2, 16'd0);
        cfg_done();
        send_sample(12'd1500, 12'd0);
        send_sample(12'd1500, 12'd0);
        send_sample(12'd1500, 12'd0);
        send_sample(12'd1510, 12'd0);
        send_sample(12'd1490, 12'd0);
        send_sample(12'd1500, 12'd0);

        // Random phases with changing settings and idling
        for (phase = 0; phase < 8; phase++)
        begin
            drop_valid();
            wait_drained();
            random_setup(phase % 3 == 0);
            gap_pct   = (phase == 4) ? 0 : 25;
            stall_pct = (phase == 5) ? 0 : 25;
            if (phase == 2)
            begin
                // Fill the pipeline behind a long output hold
                gap_pct      = 0;
                hold_request = 1'b1;
            end
            send_mixed(75, $urandom_range(400, 3800));
        end

        // Closing stretch with no idling on either side
        drop_valid();
        wait_drained();
        random_setup(1'b0);
        gap_pct   = 0;
        stall_pct = 0;
        send_mixed(30, $urandom_range(400, 3800));
        drop_valid();

        for (wait_cycles = 0; wait_cycles < DRAIN_LIMIT && fan_model.pending() != 0;
             wait_cycles++)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fan_model.pending() != 0)
            fan_model.report($sformatf("%0d expected beats never arrived",
                                       fan_model.pending()));
        if (fan_model.error_count == 0)
            $display("thermal_fan_hysteresis_monitor test passed");
        else
            $display("thermal_fan_hysteresis_monitor test failed");
        $finish;
    end

endmodule

`default_nettype wire

### thermal_fan_hysteresis_monitor.f
+incdir+rtl
rtl/tfhm_pkg.sv
rtl/tfhm_history.sv
rtl/thermal_fan_hysteresis_monitor.sv
rtl/tfhm_checker.sv
tb/thermal_fan_hysteresis_monitor_test.sv
